FILE: rtl/core/ssd_pkg.sv
// shared types and constants for the segment-to-segment distance pipeline
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;

  // field widths
  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 16;
  localparam int EPS_W     = 33;
  localparam int DIST_W    = 33;

  // derived arithmetic widths
  localparam int DIFF_W = COORD_W + 1;      // coordinate difference
  localparam int PROD_W = 2 * DIFF_W;       // one signed product
  localparam int SUM_W  = PROD_W + 1;       // sum of two products
  localparam int SQ_W   = 2 * COORD_W + 1;  // squared length, unsigned
  localparam int CRM_W  = SQ_W;             // cross product magnitude
  localparam int SQR_W  = 2 * CRM_W;        // cross magnitude squared
  localparam int NUM_W  = SQR_W + 2 * FRAC_BITS;
  localparam int Q_W    = SQ_W + 2 * FRAC_BITS;  // scaled squared distance

  // divider: quotient bits per stage
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (Q_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QP_W       = DIV_STAGES * DIV_STEP;

  // square root: root bits per stage
  localparam int RT_STEP   = 3;
  localparam int RT_STAGES = ((Q_W + 1) / 2 + RT_STEP - 1) / RT_STEP;
  localparam int RP_W      = RT_STAGES * RT_STEP;
  localparam int RAD_W     = 2 * RP_W;
  localparam int REM_W     = RP_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [EPS_W-1:0]          eps_t;
  typedef logic [Q_W-1:0]            cand_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  // orientation of a point against a directed segment
  typedef enum logic [2:0] {
    OR_ON,
    OR_CCW,
    OR_CW,
    OR_BEHIND,
    OR_BEYOND
  } orient_t;

  typedef struct packed {
    logic valid;
    vec_t dir;      // segment end minus start
    vec_t rel;      // point minus segment start
    vec_t rel_end;  // point minus segment end
  } ptseg_in_t;

  typedef struct packed {
    logic    valid;
    orient_t orient;
    cand_t   cand;  // floor(2^(2*FRAC_BITS) * squared distance)
  } ptseg_out_t;

endpackage
`default_nettype wire

FILE: rtl/core/segment_segment_distance.sv
// top level: shortest distance between two 2d segments, fully pipelined
//
// channel   ports                              handshake
// -------   --------------------------------   ---------------------------------
// input     in_a_*, in_b_* (8 x 16 bit signed)  word taken when start && !busy
// result    out_distance, out_segments_touch   out_valid high for one cycle
// config    cfg_wdata (33 bit)                 cfg_we, written the same edge
//
// one word can enter every cycle while busy is low; the four-bit-per-stage
// divider and the root extractor are both unrolled into pipeline stages
// busy is high only while rst_n is low (synchronous reset clears valid bits
// and the tolerance register)
// the receiver cannot stall, so words never wait inside the pipeline
`timescale 1ns / 1ps
`default_nettype none
module segment_segment_distance (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ssd_pkg::COORD_W-1:0] in_a_start_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] in_a_start_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] in_a_end_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] in_a_end_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] in_b_start_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] in_b_start_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] in_b_end_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] in_b_end_y,
  input  logic                          cfg_we,
  input  logic [ssd_pkg::EPS_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output logic [ssd_pkg::DIST_W-1:0]    out_distance,
  output logic                          out_segments_touch
);
  import ssd_pkg::*;

  localparam int SAT_W = (RP_W > DIST_W) ? RP_W : DIST_W;

  // sign of an orientation code: ccw and behind are positive, cw and beyond negative
  function automatic logic or_pos(orient_t o);
    return (o == OR_CCW) || (o == OR_BEHIND);
  endfunction

  function automatic logic or_neg(orient_t o);
    return (o == OR_CW) || (o == OR_BEYOND);
  endfunction

  function automatic vec_t vsub(pt_t p, pt_t q);
    vec_t r;
    r.x = DIFF_W'(p.x) - DIFF_W'(q.x);
    r.y = DIFF_W'(p.y) - DIFF_W'(q.y);
    return r;
  endfunction

  logic       accept;
  eps_t       eps_r;

  // input register
  logic       v1_r;
  pt_t        a0_r, a1_r, b0_r, b1_r;

  // difference register
  logic       v2_r;
  vec_t       da_r, db_r;
  vec_t       b0a0_r, b1a0_r, b0a1_r, b1a1_r;
  vec_t       a0b0_r, a1b0_r, a0b1_r, a1b1_r;

  ptseg_in_t  seg_in [4];
  ptseg_out_t seg_out[4];

  // min tree
  logic       touch;
  logic       mv1_r, mt1_r, mv2_r, mt2_r;
  cand_t      m01_r, m23_r, mmin_r;

  // root and output
  logic              sq_valid, sq_tag;
  logic [RP_W-1:0]   sq_root;
  logic [SAT_W-1:0]  root_ext;
  logic [DIST_W-1:0] dist_nxt;
  logic              ov_r;
  logic              ot_r;
  logic [DIST_W-1:0] od_r;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      mv1_r <= 1'b0;
      mv2_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      v1_r  <= accept;
      v2_r  <= v1_r;
      mv1_r <= seg_out[0].valid;
      mv2_r <= mv1_r;
      ov_r  <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    a0_r <= '{x: in_a_start_x, y: in_a_start_y};
    a1_r <= '{x: in_a_end_x,   y: in_a_end_y};
    b0_r <= '{x: in_b_start_x, y: in_b_start_y};
    b1_r <= '{x: in_b_end_x,   y: in_b_end_y};

    da_r   <= vsub(a1_r, a0_r);
    db_r   <= vsub(b1_r, b0_r);
    b0a0_r <= vsub(b0_r, a0_r);
    b1a0_r <= vsub(b1_r, a0_r);
    b0a1_r <= vsub(b0_r, a1_r);
    b1a1_r <= vsub(b1_r, a1_r);
    a0b0_r <= vsub(a0_r, b0_r);
    a1b0_r <= vsub(a1_r, b0_r);
    a0b1_r <= vsub(a0_r, b1_r);
    a1b1_r <= vsub(a1_r, b1_r);
  end

  // the four point-against-segment checks: b0 and b1 on a, a0 and a1 on b
  assign seg_in[0] = '{valid: v2_r, dir: da_r, rel: b0a0_r, rel_end: b0a1_r};
  assign seg_in[1] = '{valid: v2_r, dir: da_r, rel: b1a0_r, rel_end: b1a1_r};
  assign seg_in[2] = '{valid: v2_r, dir: db_r, rel: a0b0_r, rel_end: a0b1_r};
  assign seg_in[3] = '{valid: v2_r, dir: db_r, rel: a1b0_r, rel_end: a1b1_r};

  for (genvar i = 0; i < 4; i++) begin : g_ps
    ssd_ptseg u_ptseg (
      .clk    (clk),
      .rst_n  (rst_n),
      .eps    (eps_r),
      .seg_in (seg_in[i]),
      .seg_out(seg_out[i])
    );
  end

  // each segment straddles the other when the codes of the other's endpoints
  // do not share a sign
  assign touch = !(or_pos(seg_out[0].orient) && or_pos(seg_out[1].orient)) &&
                 !(or_neg(seg_out[0].orient) && or_neg(seg_out[1].orient)) &&
                 !(or_pos(seg_out[2].orient) && or_pos(seg_out[3].orient)) &&
                 !(or_neg(seg_out[2].orient) && or_neg(seg_out[3].orient));

  // min over the squared candidates, root is monotone so it commutes
  always_ff @(posedge clk) begin
    mt1_r  <= touch;
    m01_r  <= (seg_out[1].cand < seg_out[0].cand) ? seg_out[1].cand : seg_out[0].cand;
    m23_r  <= (seg_out[3].cand < seg_out[2].cand) ? seg_out[3].cand : seg_out[2].cand;
    mt2_r  <= mt1_r;
    mmin_r <= (m23_r < m01_r) ? m23_r : m01_r;
  end

  ssd_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (mv2_r),
    .in_tag (mt2_r),
    .rad    (mmin_r),
    .out_vld(sq_valid),
    .out_tag(sq_tag),
    .root   (sq_root)
  );

  // saturate to the output width, touching segments report zero
  always_comb begin
    root_ext = SAT_W'(sq_root);
    if (sq_tag) begin
      dist_nxt = '0;
    end else if ((root_ext >> DIST_W) != '0) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = DIST_W'(root_ext);
    end
  end

  always_ff @(posedge clk) begin
    od_r <= dist_nxt;
    ot_r <= sq_tag;
  end

  assign out_valid          = ov_r;
  assign out_distance       = od_r;
  assign out_segments_touch = ot_r;

`ifndef SYNTHESIS
  a_touch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_segments_touch) |-> (out_distance == '0))
    else $error("touching segments with nonzero distance");

  a_min_pair: assert property (@(posedge clk) disable iff (!rst_n)
    mv1_r |-> ((m01_r <= $past(seg_out[0].cand)) && (m01_r <= $past(seg_out[1].cand))))
    else $error("first min stage not below its candidates");

  a_min_final: assert property (@(posedge clk) disable iff (!rst_n)
    mv2_r |-> ((mmin_r <= $past(m01_r)) && (mmin_r <= $past(m23_r))))
    else $error("final min stage not below its inputs");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/ssd_ptseg.sv
// point-to-segment unit: orientation code and scaled squared distance
`timescale 1ns / 1ps
`default_nettype none
module ssd_ptseg (
  input  logic                clk,
  input  logic                rst_n,
  input  ssd_pkg::eps_t       eps,
  input  ssd_pkg::ptseg_in_t  seg_in,
  output ssd_pkg::ptseg_out_t seg_out
);
  import ssd_pkg::*;

  localparam int CMP_W = ((SUM_W > EPS_W) ? SUM_W : EPS_W) + 2;
  localparam int LAST  = DIV_STAGES - 1;

  // stage 1: products
  logic                     v1_r;
  logic signed [PROD_W-1:0] p_rx_r, p_ry_r, p_cx_r, p_cy_r, p_lx_r, p_ly_r;
  logic signed [PROD_W-1:0] p_ax_r, p_ay_r, p_bx_r, p_by_r, p_ex_r, p_ey_r;

  // stage 2: dot and cross products
  logic                    v2_r;
  logic signed [SUM_W-1:0] dot1_r, dte_r, cr_r;
  logic [SQ_W-1:0]         len2_r, d0_r, d1_r;

  // stage 3: classification
  logic             v3_r, perp3_r;
  orient_t          or3_r, or3_nxt;
  logic [SQ_W-1:0]  ep3_r, ep3_nxt, dl3_r, dl3_nxt;
  logic [CRM_W-1:0] crm3_r, crm3_nxt;
  logic             perp3_nxt;
  logic signed [CMP_W-1:0] cr_s, eps_s, neps_s, dot1_s;

  // stage 4: cross magnitude squared
  logic             v4_r, perp4_r;
  orient_t          or4_r;
  logic [SQ_W-1:0]  ep4_r, dl4_r;
  logic [SQR_W-1:0] sq4_r;
  logic [NUM_W-1:0] num;
  logic [SQ_W-1:0]  rem0;
  logic [QP_W-1:0]  lo0;

  // divider stages
  logic [SQ_W-1:0] drem_r [DIV_STAGES];
  logic [QP_W-1:0] dlo_r  [DIV_STAGES];
  logic            dv_r   [DIV_STAGES];
  orient_t         dor_r  [DIV_STAGES];
  logic            dperp_r[DIV_STAGES];
  logic [SQ_W-1:0] dep_r  [DIV_STAGES];
  logic [SQ_W-1:0] ddl_r  [DIV_STAGES];

  // output stage
  logic    ov_r;
  orient_t oor_r;
  cand_t   ocand_r, ocand_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= seg_in.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    p_rx_r <= PROD_W'(seg_in.dir.x) * PROD_W'(seg_in.rel.x);
    p_ry_r <= PROD_W'(seg_in.dir.y) * PROD_W'(seg_in.rel.y);
    p_cx_r <= PROD_W'(seg_in.dir.x) * PROD_W'(seg_in.rel.y);
    p_cy_r <= PROD_W'(seg_in.dir.y) * PROD_W'(seg_in.rel.x);
    p_lx_r <= PROD_W'(seg_in.dir.x) * PROD_W'(seg_in.dir.x);
    p_ly_r <= PROD_W'(seg_in.dir.y) * PROD_W'(seg_in.dir.y);
    p_ax_r <= PROD_W'(seg_in.rel.x) * PROD_W'(seg_in.rel.x);
    p_ay_r <= PROD_W'(seg_in.rel.y) * PROD_W'(seg_in.rel.y);
    p_bx_r <= PROD_W'(seg_in.rel_end.x) * PROD_W'(seg_in.rel_end.x);
    p_by_r <= PROD_W'(seg_in.rel_end.y) * PROD_W'(seg_in.rel_end.y);
    p_ex_r <= PROD_W'(seg_in.dir.x) * PROD_W'(seg_in.rel_end.x);
    p_ey_r <= PROD_W'(seg_in.dir.y) * PROD_W'(seg_in.rel_end.y);

    dot1_r <= SUM_W'(p_rx_r) + SUM_W'(p_ry_r);
    dte_r  <= SUM_W'(p_ex_r) + SUM_W'(p_ey_r);
    cr_r   <= SUM_W'(p_cx_r) - SUM_W'(p_cy_r);
    len2_r <= SQ_W'(SUM_W'(p_lx_r) + SUM_W'(p_ly_r));
    d0_r   <= SQ_W'(SUM_W'(p_ax_r) + SUM_W'(p_ay_r));
    d1_r   <= SQ_W'(SUM_W'(p_bx_r) + SUM_W'(p_by_r));

    or3_r   <= or3_nxt;
    perp3_r <= perp3_nxt;
    ep3_r   <= ep3_nxt;
    dl3_r   <= dl3_nxt;
    crm3_r  <= crm3_nxt;

    or4_r   <= or3_r;
    perp4_r <= perp3_r;
    ep4_r   <= ep3_r;
    dl4_r   <= dl3_r;
    sq4_r   <= SQR_W'(crm3_r) * SQR_W'(crm3_r);
  end

  // orientation and distance case
  always_comb begin
    cr_s   = CMP_W'(cr_r);
    dot1_s = CMP_W'(dot1_r);
    eps_s  = $signed(CMP_W'(eps));
    neps_s = -eps_s;

    if (cr_s > eps_s) begin
      or3_nxt = OR_CCW;
    end else if (cr_s < neps_s) begin
      or3_nxt = OR_CW;
    end else if (dot1_s < neps_s) begin
      or3_nxt = OR_BEHIND;
    end else if (len2_r < d0_r) begin
      or3_nxt = OR_BEYOND;
    end else begin
      or3_nxt = OR_ON;
    end

    // behind start, beyond end, degenerate segment, else perpendicular
    perp3_nxt = 1'b0;
    ep3_nxt   = d0_r;
    if (dot1_r < 0) begin
      ep3_nxt = d0_r;
    end else if (dte_r > 0) begin
      ep3_nxt = d1_r;
    end else if (len2_r == '0) begin
      ep3_nxt = d0_r;
    end else begin
      perp3_nxt = 1'b1;
    end

    dl3_nxt  = (len2_r == '0) ? SQ_W'(1) : len2_r;
    crm3_nxt = cr_r[SUM_W-1] ? CRM_W'(-cr_r) : CRM_W'(cr_r);
  end

  assign num  = NUM_W'(sq4_r) << (2 * FRAC_BITS);
  assign rem0 = SQ_W'(num >> QP_W);
  assign lo0  = QP_W'(num);

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [SQ_W-1:0] r_in, r_out, d_in, ep_in;
    logic [QP_W-1:0] l_in, l_out;
    logic [SQ_W:0]   t;
    logic            v_in, perp_in;
    orient_t         or_in;

    if (k == 0) begin : g_first
      assign r_in    = rem0;
      assign l_in    = lo0;
      assign d_in    = dl4_r;
      assign v_in    = v4_r;
      assign or_in   = or4_r;
      assign perp_in = perp4_r;
      assign ep_in   = ep4_r;
    end else begin : g_next
      assign r_in    = drem_r[k-1];
      assign l_in    = dlo_r[k-1];
      assign d_in    = ddl_r[k-1];
      assign v_in    = dv_r[k-1];
      assign or_in   = dor_r[k-1];
      assign perp_in = dperp_r[k-1];
      assign ep_in   = dep_r[k-1];
    end

    // restoring division, DIV_STEP quotient bits
    always_comb begin
      r_out = r_in;
      l_out = l_in;
      t     = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
        t     = {r_out, l_out[QP_W-1]};
        l_out = l_out << 1;
        if (t >= {1'b0, d_in}) begin
          r_out    = SQ_W'(t - {1'b0, d_in});
          l_out[0] = 1'b1;
        end else begin
          r_out = SQ_W'(t);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else begin
        dv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      drem_r[k]  <= r_out;
      dlo_r[k]   <= l_out;
      ddl_r[k]   <= d_in;
      dor_r[k]   <= or_in;
      dperp_r[k] <= perp_in;
      dep_r[k]   <= ep_in;
    end
  end

  assign ocand_nxt = dperp_r[LAST] ? Q_W'(dlo_r[LAST])
                                   : (Q_W'(dep_r[LAST]) << (2 * FRAC_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    oor_r   <= dor_r[LAST];
    ocand_r <= ocand_nxt;
  end

  assign seg_out.valid  = ov_r;
  assign seg_out.orient = oor_r;
  assign seg_out.cand   = ocand_r;

endmodule
`default_nettype wire

FILE: rtl/core/ssd_isqrt.sv
// pipelined integer square root, RT_STEP root bits per stage
`timescale 1ns / 1ps
`default_nettype none
module ssd_isqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic                     in_tag,
  input  logic [ssd_pkg::Q_W-1:0]  rad,
  output logic                     out_vld,
  output logic                     out_tag,
  output logic [ssd_pkg::RP_W-1:0] root
);
  import ssd_pkg::*;

  localparam int LAST = RT_STAGES - 1;

  logic [REM_W-1:0] srem_r [RT_STAGES];
  logic [RP_W-1:0]  sroot_r[RT_STAGES];
  logic [RAD_W-1:0] srad_r [RT_STAGES];
  logic             sv_r   [RT_STAGES];
  logic             stag_r [RT_STAGES];

  for (genvar k = 0; k < RT_STAGES; k++) begin : g_rt
    logic [REM_W-1:0] m_in, m_out, rs, trial;
    logic [RP_W-1:0]  q_in, q_out;
    logic [RAD_W-1:0] a_in, a_out;
    logic             v_in, tag_in;

    if (k == 0) begin : g_first
      assign m_in   = '0;
      assign q_in   = '0;
      assign a_in   = RAD_W'(rad);
      assign v_in   = in_vld;
      assign tag_in = in_tag;
    end else begin : g_next
      assign m_in   = srem_r[k-1];
      assign q_in   = sroot_r[k-1];
      assign a_in   = srad_r[k-1];
      assign v_in   = sv_r[k-1];
      assign tag_in = stag_r[k-1];
    end

    always_comb begin
      m_out = m_in;
      q_out = q_in;
      a_out = a_in;
      rs    = '0;
      trial = '0;
      for (int j = 0; j < RT_STEP; j++) begin
        rs    = (m_out << 2) | REM_W'(a_out[RAD_W-1 -: 2]);
        a_out = a_out << 2;
        trial = (REM_W'(q_out) << 2) | REM_W'(1);
        if (rs >= trial) begin
          m_out = rs - trial;
          q_out = (q_out << 1) | RP_W'(1);
        end else begin
          m_out = rs;
          q_out = q_out << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else begin
        sv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      srem_r[k]  <= m_out;
      sroot_r[k] <= q_out;
      srad_r[k]  <= a_out;
      stag_r[k]  <= tag_in;
    end
  end

  assign out_vld = sv_r[LAST];
  assign out_tag = stag_r[LAST];
  assign root    = sroot_r[LAST];

endmodule
`default_nettype wire
